// ===== rtl/ckf_pkg.sv =====
// shared types, constants and helper functions for the color key fill block
`timescale 1ns / 1ps
`default_nettype none

package ckf_pkg;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int SUM_W     = 12;
  localparam int CNT_W     = 4;
  localparam int NB_W      = 3;
  localparam int RCP_W     = 17;
  localparam int RCP_SH    = 16;
  localparam int DIAG_W    = 9;
  localparam int SQRT2_Q16 = 92682;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [NB_W-1:0] NB_LAST = 3'd7;
  localparam logic [1:0]      CH_LAST = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDC  = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_NRD  = 8'b0000_1000,
    S_NAC  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } ckf_state_t;

  typedef struct packed {
    logic take;
    logic rd_ctr;
    logic chk;
    logic nb_acc;
    logic div;
    logic fin;
    logic load_out;
  } ckf_cmd_t;

  typedef struct packed {
    logic need_out;
    logic ctr_key;
    logic nb_last;
    logic div_last;
    logic out_free;
  } ckf_sts_t;

  function automatic logic is_key(input logic [PIX_W-1:0] p);
    return p[23:0] == 24'hFF0000;
  endfunction

  // floor(v * sqrt2), exact for 8-bit v
  function automatic logic [DIAG_W-1:0] diag_weight(input logic [CH_W-1:0] v);
    logic [24:0] p;
    p = 25'(v) * 25'(SQRT2_Q16);
    return p[24:16];
  endfunction

  // ceil(2^16 / c) for c in 1..8
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] c);
    logic [RCP_W-1:0] r;
    unique case (c)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

  // neighbour order: up-left, up, up-right, left, right, down-left, down, down-right
  function automatic logic nb_up(input logic [NB_W-1:0] k);
    return k <= 3'd2;
  endfunction

  function automatic logic nb_down(input logic [NB_W-1:0] k);
    return k >= 3'd5;
  endfunction

  function automatic logic nb_left(input logic [NB_W-1:0] k);
    return k == 3'd0 || k == 3'd3 || k == 3'd5;
  endfunction

  function automatic logic nb_right(input logic [NB_W-1:0] k);
    return k == 3'd2 || k == 3'd4 || k == 3'd7;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ckf_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ckf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ckf_dp.sv =====
// datapath: positions, line store, neighbour accumulation, division, output register
`timescale 1ns / 1ps
`default_nettype none

module ckf_dp
  import ckf_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ckf_cmd_t             cmd,
  output ckf_sts_t             sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic                 in_flush,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,
  output logic                 out_tlast
);

  localparam int IW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2 ** CFG_W + 4);
  localparam int AW    = $clog2(2 * MAX_WIDTH + 3);
  localparam int DEPTH = 2 ** AW;

  logic [CFG_W-1:0] w_r, h_r, w_c, h_c;
  logic [IW-1:0]    in_idx_r, o_r, cur_o_r;
  logic             all_rcv_r;
  logic [CFG_W-1:0] ocol_r, orow_r, cur_col_r, cur_row_r;
  logic             cur_last_r;
  logic [NB_W-1:0]  k_r;
  logic [1:0]       ch_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sum_r [3];
  logic [CH_W-1:0]  avg_r [3];
  logic [PIX_W-1:0] result_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;

  logic             live, done_now, ready, o_last;
  logic [IW-1:0]    received, total;
  logic [AW-1:0]    ram_raddr, nb_addr, wa, row_off, col_off;
  logic [PIX_W-1:0] ram_rdata;
  logic             nb_ok, nb_key;
  logic [RCP_W+SUM_W-1:0] prod;
  logic [RCP_W+SUM_W-RCP_SH-1:0] quot;

  always_comb begin
    if (w_r == '0) begin
      w_c = CFG_W'(1);
    end else if (32'(w_r) > MAX_WIDTH) begin
      w_c = CFG_W'(MAX_WIDTH);
    end else begin
      w_c = w_r;
    end
    if (h_r == '0) begin
      h_c = CFG_W'(1);
    end else if (32'(h_r) > MAX_HEIGHT) begin
      h_c = CFG_W'(MAX_HEIGHT);
    end else begin
      h_c = h_r;
    end
  end

  assign total    = IW'(w_c) * IW'(h_c);
  assign live     = !in_flush && !all_rcv_r;
  assign done_now = all_rcv_r || (live && in_idx_r == total - IW'(1));
  assign received = in_idx_r + IW'(live);
  assign ready    = done_now || received >= o_r + IW'(w_c) + IW'(2);
  assign o_last   = o_r == total - IW'(1);

  // neighbour address in the ring
  assign wa      = AW'(w_c);
  assign row_off = nb_up(k_r) ? -wa : (nb_down(k_r) ? wa : '0);
  assign col_off = nb_left(k_r) ? '1 : (nb_right(k_r) ? AW'(1) : '0);
  assign nb_addr = cur_o_r[AW-1:0] + row_off + col_off;
  assign ram_raddr = cmd.rd_ctr ? cur_o_r[AW-1:0] : nb_addr;

  assign nb_ok = !(nb_left(k_r) && cur_col_r == '0)
              && !(nb_right(k_r) && cur_col_r == w_c - CFG_W'(1))
              && !(nb_up(k_r) && cur_row_r == '0)
              && !(nb_down(k_r) && cur_row_r == h_c - CFG_W'(1));
  assign nb_key = is_key(ram_rdata);

  assign prod = (RCP_W+SUM_W)'(sum_r[ch_r]) * (RCP_W+SUM_W)'(recip(cnt_r));
  assign quot = prod[RCP_W+SUM_W-1:RCP_SH];

  ckf_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_line (
    .clk   (clk),
    .we    (cmd.take && live),
    .waddr (in_idx_r[AW-1:0]),
    .wdata (in_pixel),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= CFG_W'(16);
      h_r         <= CFG_W'(16);
      in_idx_r    <= '0;
      all_rcv_r   <= 1'b0;
      o_r         <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_WIDTH:  w_r <= cfg_wdata;
          REG_HEIGHT: h_r <= cfg_wdata;
          default:    w_r <= w_r;
        endcase
        in_idx_r  <= '0;
        all_rcv_r <= 1'b0;
        o_r       <= '0;
        ocol_r    <= '0;
        orow_r    <= '0;
      end else if (cmd.take) begin
        if (live) begin
          if (done_now) begin
            in_idx_r  <= '0;
            all_rcv_r <= 1'b1;
          end else begin
            in_idx_r <= in_idx_r + IW'(1);
          end
        end
        if (ready) begin
          if (o_last) begin
            o_r       <= '0;
            ocol_r    <= '0;
            orow_r    <= '0;
            in_idx_r  <= '0;
            all_rcv_r <= 1'b0;
          end else begin
            o_r <= o_r + IW'(1);
            if (ocol_r == w_c - CFG_W'(1)) begin
              ocol_r <= '0;
              orow_r <= orow_r + CFG_W'(1);
            end else begin
              ocol_r <= ocol_r + CFG_W'(1);
            end
          end
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_o_r    <= o_r;
      cur_col_r  <= ocol_r;
      cur_row_r  <= orow_r;
      cur_last_r <= o_last;
    end
    if (cmd.chk) begin
      result_r <= ram_rdata;
      k_r      <= '0;
      ch_r     <= '0;
      cnt_r    <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
    end
    if (cmd.nb_acc) begin
      k_r <= k_r + NB_W'(1);
      if (nb_ok) begin
        if (!nb_key) begin
          cnt_r <= cnt_r + CNT_W'(1);
          for (int i = 0; i < 3; i++) begin
            if ((nb_left(k_r) || nb_right(k_r)) && (nb_up(k_r) || nb_down(k_r))) begin
              sum_r[i] <= sum_r[i] + SUM_W'(diag_weight(ram_rdata[i*CH_W +: CH_W]));
            end else begin
              sum_r[i] <= sum_r[i] + SUM_W'(ram_rdata[i*CH_W +: CH_W]);
            end
          end
        end else if (!k_r[2]) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
    if (cmd.div) begin
      avg_r[ch_r] <= (quot > 255) ? CH_W'(255) : quot[CH_W-1:0];
      ch_r <= ch_r + 2'd1;
    end
    if (cmd.fin) begin
      if (cnt_r == '0 || (avg_r[0] == '0 && avg_r[1] == '0 && avg_r[2] == CH_W'(255))) begin
        result_r <= '0;
      end else begin
        result_r <= {CH_W'(0), avg_r[2], avg_r[1], avg_r[0]};
      end
    end
    if (cmd.load_out) begin
      out_data_r <= result_r;
      out_last_r <= cur_last_r;
    end
  end

  assign sts.need_out = ready;
  assign sts.ctr_key  = nb_key;
  assign sts.nb_last  = k_r == NB_LAST;
  assign sts.div_last = ch_r == CH_LAST;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/ckf_ctrl.sv =====
// controller state machine sequencing one request through the datapath
`timescale 1ns / 1ps
`default_nettype none

module ckf_ctrl
  import ckf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  ckf_sts_t sts,
  output ckf_cmd_t cmd
);

  ckf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        if (in_tvalid && sts.need_out) begin
          state_nxt = S_RDC;
        end
      end
      S_RDC: begin
        cmd.rd_ctr = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.ctr_key ? S_NRD : S_OUT;
      end
      S_NRD: begin
        state_nxt = S_NAC;
      end
      S_NAC: begin
        cmd.nb_acc = 1'b1;
        state_nxt  = sts.nb_last ? S_DIV : S_NRD;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/color_key_transparency_fill.sv =====
// top level of the color key transparency fill block
//
// Pixels enter in raster order on the in_ stream; in_tuser set marks a flush
// request that carries no pixel and only drains pending results. Results
// leave on the out_ stream one row plus one pixel behind the input; out_tlast
// marks the last pixel of the image. Once the whole image is in, every
// further request (flush or pixel) releases the next pending pixel.
// image_width (index 0) and image_height (index 1) are to be written on the
// cfg_ port only while the block is idle, which the block does not enforce;
// a write restarts the image. Requests are handled one at a time. A request
// yielding a plain pixel passes S_RDC, S_CHK and S_OUT, where the output is
// loaded; one yielding a filled key pixel also does the eight neighbour reads
// (S_NRD, S_NAC) one after another on the line store's single read port,
// followed by three reciprocal multiplies (S_DIV) and S_FIN before S_OUT.
// Reset (synchronous, rst_n low) empties the output register, clears the
// input and output positions and sets both dimensions to 16. The line store
// needs no clearing. When out_tready is low the result stays in the output
// register and the block stops before loading the next one.
`timescale 1ns / 1ps
`default_nettype none

module color_key_transparency_fill
  import ckf_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,   // red, green, blue, alpha
  input  logic                 in_tuser,   // flush
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ckf_cmd_t cmd;
  ckf_sts_t sts;

  ckf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ckf_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_pixel   (in_tdata),
    .in_flush   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/ckf_checker.sv =====
// port-level checks for the color key fill block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ckf_checker
  import ckf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [PIX_W-1:0] out_tdata
);

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a stalled result is neither dropped nor altered
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // key color never leaves the block
  a_no_key_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:0] != 24'hFF0000)
    else $error("key colored pixel on output");

endmodule

bind color_key_transparency_fill ckf_checker u_ckf_checker (.*);

`default_nettype wire
